FILE: design/volatility_halt_and_price_band_guard_defines.svh
// ---------------------------------------------------------------------------
// Volatility halt and price band guard: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef VOLATILITY_HALT_AND_PRICE_BAND_GUARD_DEFINES_SVH
`define VOLATILITY_HALT_AND_PRICE_BAND_GUARD_DEFINES_SVH

// Same-cycle implication.
`define VHG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VHG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/vhg_pkg.sv
// ---------------------------------------------------------------------------
// vhg_pkg
// Types, widths and codes shared by the volatility halt and price band guard.
// ---------------------------------------------------------------------------
package vhg_pkg;

  localparam int VHG_SYMBOLS = 256;
  localparam int SYM_W       = 8;
  localparam int PRICE_W     = 32;
  localparam int TIME_W      = 32;
  localparam int FRAC_W      = 17;
  localparam int HSEC_W      = 16;
  localparam int MUL_B_W     = FRAC_W + 1;
  localparam int PROD_W      = PRICE_W + MUL_B_W;
  localparam int Q16_ONE     = 65536;

  localparam logic [HSEC_W-1:0] HSEC_RESET = HSEC_W'(120);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALT_FRAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_FRAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALT_SEC  = 2'd2;

  // verdict codes
  localparam logic [1:0] V_ACCEPT = 2'd0;
  localparam logic [1:0] V_HALTED = 2'd1;
  localparam logic [1:0] V_BAND   = 2'd2;
  localparam logic [1:0] V_TRADE  = 2'd3;

  // one table word per symbol
  typedef struct packed {
    logic               halted;
    logic [TIME_W-1:0]  deadline;
    logic [PRICE_W-1:0] last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/vhg_ram.sv
// ---------------------------------------------------------------------------
// vhg_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module vhg_ram
  import vhg_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = VHG_SYMBOLS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/volatility_halt_and_price_band_guard.sv
// ---------------------------------------------------------------------------
// volatility_halt_and_price_band_guard
// Per-symbol pre-trade guard: volatility halts on trades, halt and price
// band checks on new orders, all per-symbol state in one symbol table RAM.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per item; in_tuser = op (0 trade fill, 1 order check),
//           in_tdata = symbol, price, time. Taken only while the block is idle.
//   out_* : exactly one result transfer per item (verdict and halt flags).
//   cfg_* : write-only register port, one write per cycle with cfg_we high;
//           write it only while no item is in flight.
// Timing:
//   An item goes through these steps: accept (table read issued), table
//   data back and first product, second product, then compare with table
//   write-back and result load. One shared 32x18 multiplier forms the halt
//   product and both band products. Only one item is in flight at a time. The
//   result is visible the cycle after the compare step; it waits in the
//   output register while the next item is accepted and worked on.
// Reset:
//   rst_n low clears control and the fractions; halt seconds reset to 120.
//   After reset the block sweeps all min(SYMBOLS, 256) entries to zero, one
//   entry a cycle, in_tready low; configuration writes are taken during it.
// Stall:
//   If a new result finds the output register full with out_tready low, it
//   waits in the compare step (table not yet written) until that frees up.
// ---------------------------------------------------------------------------
`include "volatility_halt_and_price_band_guard_defines.svh"

module volatility_halt_and_price_band_guard
  import vhg_pkg::*;
#(
  parameter int SYMBOLS = VHG_SYMBOLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,   // symbol_index[7:0], price[39:8], now_seconds[71:40]
  input  logic                 in_tuser,   // op
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // verdict[1:0], halt_started[2], halt_ended[3], zero
  // configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_W-1:0]    cfg_wdata
);

  // Only 256 symbol codes can reach the table, so it never grows past that.
  localparam int DEPTH = (SYMBOLS < (1 << SYM_W)) ? SYMBOLS : (1 << SYM_W);
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD    = 5'b00100,
    S_MUL   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [FRAC_W-1:0] hf_r;
  logic [FRAC_W-1:0] bf_r;
  logic [HSEC_W-1:0] hs_r;

  // captured item
  logic               op_r;
  logic [AW-1:0]      sym_r;
  logic [PRICE_W-1:0] price_r;
  logic [TIME_W-1:0]  now_r;

  // working registers
  entry_t             ent_r;
  logic [PROD_W-1:0]  prod1_r;
  logic [PROD_W-1:0]  prod2_r;
  logic [PRICE_W-1:0] diff_r;
  logic [TIME_W-1:0]  dl_r;
  logic               expired_r;
  logic [AW-1:0]      clr_cnt_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_verdict_r;
  logic       out_started_r;
  logic       out_ended_r;

  // symbol code to table address, worked out at elaboration
  logic [AW-1:0] sym_map [1 << SYM_W];
  for (genvar g = 0; g < (1 << SYM_W); g++) begin : g_sym_map
    assign sym_map[g] = AW'(g % SYMBOLS);
  end

  // RAM port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  vhg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  logic in_fire;
  logic out_free;
  logic fin_go;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign fin_go    = (state_r == S_FIN) && out_free;

  // Shared multiplier: first pass straight off the RAM output, second from
  // the captured entry. Trades use the halt fraction, orders the lower band
  // factor first and the upper band factor second.
  logic [PRICE_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [MUL_B_W-1:0] band_lo_k;
  logic [MUL_B_W-1:0] band_hi_k;

  assign band_lo_k = MUL_B_W'(Q16_ONE) - {1'b0, bf_r};
  assign band_hi_k = MUL_B_W'(Q16_ONE) + {1'b0, bf_r};

  always_comb begin
    if (state_r == S_RD) begin
      mul_a = mem_rdata.last;
      mul_b = op_r ? band_lo_k : {1'b0, hf_r};
    end else begin
      mul_a = ent_r.last;
      mul_b = band_hi_k;
    end
  end

  assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{PRICE_W{1'b0}}, mul_b};

  // saturating deadline and absolute move, registered in the product step
  logic [TIME_W:0]    dl_sum;
  logic [PRICE_W-1:0] diff_c;

  assign dl_sum = {1'b0, now_r} + {{(TIME_W + 1 - HSEC_W){1'b0}}, hs_r};
  assign diff_c = (price_r >= ent_r.last) ? (price_r - ent_r.last) : (ent_r.last - price_r);

  // Final decision
  logic [PROD_W-1:0] scaled;
  logic [PROD_W-1:0] move_scaled;
  logic              halt_hit;
  logic              halt_check;
  logic              band_check;
  logic              band_out;
  logic [1:0]        verdict_c;
  logic              started_c;
  logic              ended_c;
  logic              wr_c;
  entry_t            new_ent;

  assign scaled      = {{(PROD_W - PRICE_W - 16){1'b0}}, price_r, 16'd0};
  assign move_scaled = {{(PROD_W - PRICE_W - 16){1'b0}}, diff_r, 16'd0};

  always_comb begin
    halt_hit   = (hf_r != '0) && (ent_r.last != '0) && (move_scaled >= prod1_r);
    halt_check = (hf_r != '0) && ent_r.halted;
    band_out   = ((bf_r < FRAC_W'(Q16_ONE)) && (scaled < prod1_r)) || (scaled > prod2_r);
    band_check = (bf_r != '0) && (price_r != '0) && (ent_r.last != '0);
    verdict_c  = V_TRADE;
    started_c  = 1'b0;
    ended_c    = 1'b0;
    wr_c       = 1'b0;
    new_ent    = ent_r;
    if (!op_r) begin
      // trade fill: maybe start a halt, then take the fill as last price
      if (price_r != '0) begin
        wr_c         = 1'b1;
        new_ent.last = price_r;
        if (halt_hit) begin
          started_c        = 1'b1;
          new_ent.halted   = 1'b1;
          new_ent.deadline = dl_r;
        end
      end
    end else begin
      // order check: halt first, then band
      verdict_c = V_ACCEPT;
      if (halt_check) begin
        if (expired_r) begin
          ended_c        = 1'b1;
          wr_c           = 1'b1;
          new_ent.halted = 1'b0;
        end else begin
          verdict_c = V_HALTED;
        end
      end
      if ((verdict_c == V_ACCEPT) && band_check && band_out) begin
        verdict_c = V_BAND;
      end
    end
  end

  // RAM port drive
  always_comb begin
    mem_re    = in_fire;
    mem_raddr = sym_map[in_tdata[SYM_W-1:0]];
    mem_we    = 1'b0;
    mem_waddr = sym_r;
    mem_wdata = new_ent;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (fin_go) begin
      mem_we = wr_c;
    end
  end

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      hf_r        <= '0;
      bf_r        <= '0;
      hs_r        <= HSEC_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      // drop the result on transfer, load a new one when the compare retires
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HALT_FRAC: hf_r <= cfg_wdata;
          CFG_BAND_FRAC: bf_r <= cfg_wdata;
          CFG_HALT_SEC:  hs_r <= cfg_wdata[HSEC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_tuser;
      sym_r   <= sym_map[in_tdata[SYM_W-1:0]];
      price_r <= in_tdata[SYM_W +: PRICE_W];
      now_r   <= in_tdata[SYM_W + PRICE_W +: TIME_W];
    end
    if (state_r == S_RD) begin
      ent_r   <= mem_rdata;
      prod1_r <= mul_p;
    end
    if (state_r == S_MUL) begin
      prod2_r   <= mul_p;
      diff_r    <= diff_c;
      dl_r      <= dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
      expired_r <= (now_r >= ent_r.deadline);
    end
    if (fin_go) begin
      out_verdict_r <= verdict_c;
      out_started_r <= started_c;
      out_ended_r   <= ended_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_ended_r, out_started_r, out_verdict_r};

  // assertions
  `VHG_ASSERT_NEXT(a_accept_reads, in_fire, state_r == S_RD, "accepted item did not go to table read")
  `VHG_ASSERT_NEXT(a_result_from_fin, !out_valid_r && !fin_go, !out_valid_r, "result appeared without a compare step")
  `VHG_ASSERT_NOW(a_started_trade, out_valid_r && out_started_r, out_verdict_r == V_TRADE, "halt start flagged on an order")
  `VHG_ASSERT_NOW(a_ended_accept, out_valid_r && out_ended_r, out_verdict_r != V_TRADE && out_verdict_r != V_HALTED, "halt release with wrong verdict")
  `VHG_ASSERT_NOW(a_clear_writes, state_r == S_CLEAR, mem_we && !in_tready, "table sweep stalled or input open")

endmodule
